// File: rtl/bbd_pkg.sv
// Package for the Bayer binning downscaler: shared constants, codes, command and
// status structs, and the channel site decode. No dependencies.
package bbd_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int MAX_WIDTH_DEF   = 4096;
  localparam int MAX_BIN_DEF     = 4;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_CELL_COLORS   = 2'd0;
  localparam logic [1:0] REG_BIN_SHIFT     = 2'd1;
  localparam logic [1:0] REG_REGION_WIDTH  = 2'd2;
  localparam logic [1:0] REG_REGION_HEIGHT = 2'd3;

  localparam logic OP_TABLE = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  localparam logic [7:0] CELL_COLORS_RST = 8'd148;
  localparam logic [2:0] BIN_SHIFT_RST   = 3'd1;
  localparam logic [12:0] REGION_WIDTH_RST  = 13'd1024;
  localparam logic [15:0] REGION_HEIGHT_RST = 16'd1024;

  typedef struct packed {
    logic table_we;   // store a tone table entry
    logic pixel_rd;   // launch table and sum reads for a pixel
    logic commit;     // add, write back, advance position
    logic div_start;  // start edge block division
    logic load_out;   // move the result into the output register
  } bbd_cmd_t;

  typedef struct packed {
    logic emit;       // the pixel closes a block
    logic short_blk;  // the block is cut by the region edge
    logic div_done;   // quotients ready
  } bbd_status_t;

  // Sites feeding channel ch: {two_sites, site_mask[3:0]}.
  function automatic logic [4:0] chan_sites(input logic [7:0] colors, input logic [1:0] ch);
    logic [3:0] m;
    logic [1:0] n;
    m = '0;
    n = '0;
    for (int s = 0; s < 4; s++) begin
      if (colors[2*s +: 2] == ch && n < 2'd2) begin
        m[s] = 1'b1;
        n = n + 2'd1;
      end
    end
    if (n == 2'd0) m = 4'b0001;
    return {n == 2'd2, m};
  endfunction

endpackage

// File: rtl/bbd_ram.sv
// Generic single-port-write, registered-read RAM.
// No dependencies.
module bbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/bbd_div.sv
// Restoring divider, one quotient bit per cycle.
// No dependencies.
module bbd_div #(
  parameter int NW = 16,
  parameter int DW = 9
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic [NW-1:0] quotient,
  output logic          done
);
  localparam int CW = $clog2(NW + 1);

  logic [DW-1:0] rem;
  logic [DW-1:0] dsr;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [DW:0]   trial;
  logic [DW:0]   diff;

  assign trial = {rem, quotient[NW-1]};
  assign diff  = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dsr      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      // keep the remainder when the trial goes negative
      if (!diff[DW]) begin
        rem <= diff[DW-1:0];
      end else begin
        rem <= trial[DW-1:0];
      end
      quotient <= {quotient[NW-2:0], !diff[DW]};
    end
  end
endmodule

// File: rtl/bbd_ctrl.sv
// Controller state machine for the Bayer binning downscaler.
// Depends on bbd_pkg.
module bbd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                op,
  output logic                out_valid,
  input  logic                out_ready,
  input  bbd_pkg::bbd_status_t sts,
  output bbd_pkg::bbd_cmd_t    cmd
);
  import bbd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_ACC  = 4'b0010,
    S_DIV  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state, state_next;
  logic   acc;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign acc      = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        cmd.table_we = acc && (op == OP_TABLE);
        cmd.pixel_rd = acc && (op == OP_PIXEL);
        if (acc && op == OP_PIXEL) state_next = S_ACC;
      end
      S_ACC: begin
        cmd.commit = 1'b1;
        if (sts.emit && sts.short_blk) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end else if (sts.emit) begin
          state_next = S_OUT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_DIV: begin
        if (sts.div_done) state_next = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end
endmodule

// File: rtl/bbd_datapath.sv
// Datapath of the Bayer binning downscaler: tone tables, block sum memory,
// raster position, edge block divider and output register. Depends on bbd_pkg,
// bbd_ram and bbd_div.
module bbd_datapath #(
  parameter int SAMPLE_BITS = bbd_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_WIDTH   = bbd_pkg::MAX_WIDTH_DEF,
  parameter int MAX_BIN     = bbd_pkg::MAX_BIN_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  bbd_pkg::bbd_cmd_t    cmd,
  output bbd_pkg::bbd_status_t sts,
  input  logic                 restart,
  input  logic [7:0]           cell_colors,
  input  logic [2:0]           bin_shift,
  input  logic [12:0]          region_width,
  input  logic [15:0]          region_height,
  input  logic [15:0]          pixel_value,
  input  logic [1:0]           table_channel,
  input  logic [7:0]           table_value,
  output logic [7:0]           red,
  output logic [7:0]           green,
  output logic [7:0]           blue,
  output logic                 row_end,
  output logic                 frame_end
);
  import bbd_pkg::*;

  localparam int CB    = $clog2(MAX_WIDTH);
  localparam int WB    = CB + 1;
  localparam int SB    = CB - 1;
  localparam int STEPW = MAX_BIN + 1;
  localparam int SUMW  = 2 * MAX_BIN + 8;
  localparam int CELW  = 2 * MAX_BIN;
  localparam int DVW   = CELW + 1;

  logic [CB-1:0] col;
  logic [15:0]   row;

  // Effective (clamped) configuration.
  logic [2:0]       bin;
  logic [WB-1:0]    width;
  logic [15:0]      height;
  logic [15:0]      rw16;
  logic [STEPW-1:0] step;
  logic [STEPW-1:0] bmask;

  assign rw16 = {3'b000, region_width};

  always_comb begin
    if (bin_shift < 3'd1) begin
      bin = 3'd1;
    end else if (32'(bin_shift) > MAX_BIN) begin
      bin = 3'(MAX_BIN);
    end else begin
      bin = bin_shift;
    end
    if (rw16 < 16'd2) begin
      width = WB'(2);
    end else if (32'(rw16) > MAX_WIDTH) begin
      width = WB'(MAX_WIDTH);
    end else begin
      width = WB'(rw16);
    end
    height = (region_height < 16'd2) ? 16'd2 : region_height;
    step   = STEPW'(1) << bin;
    bmask  = step - STEPW'(1);
  end

  // Position decode.
  logic [CB-1:0] colsh;
  logic [SB-1:0] blk;
  logic [1:0]    site;
  logic          first;
  logic          col_last, row_last, last_x, last_y;
  logic [CB-1:0] x0;
  logic [15:0]   y0;
  logic [WB-1:0] dx;
  logic [15:0]   dy;
  logic [STEPW-1:0] pw, ph;
  logic [MAX_BIN-1:0] hw, hh;
  logic [CELW-1:0] cells;
  logic          short_blk;

  always_comb begin
    colsh    = col >> bin;
    blk      = colsh[SB-1:0];
    site     = {row[0], col[0]};
    first    = ((col & CB'(bmask)) == '0) && ((row & 16'(bmask)) == '0);
    col_last = ({1'b0, col} == width - WB'(1));
    row_last = (row == height - 16'd1);
    last_x   = ((col & CB'(bmask)) == CB'(bmask)) || col_last;
    last_y   = ((row & 16'(bmask)) == 16'(bmask)) || row_last;
    x0       = col & ~CB'(bmask);
    y0       = row & ~16'(bmask);
    dx       = width - {1'b0, x0};
    dy       = height - y0;
    pw       = (dx < WB'(step)) ? STEPW'(dx) : step;
    ph       = (dy < 16'(step)) ? STEPW'(dy) : step;
    hw       = MAX_BIN'((pw + STEPW'(1)) >> 1);
    hh       = MAX_BIN'((ph + STEPW'(1)) >> 1);
    cells    = CELW'(hw) * CELW'(hh);
    short_blk = (pw < step) || (ph < step);
  end

  assign sts.emit      = last_x && last_y;
  assign sts.short_blk = short_blk;

  // Tone tables, one memory per channel.
  logic [7:0] tone [3];

  for (genvar k = 0; k < 3; k++) begin : g_tone
    bbd_ram #(.WIDTH(8), .DEPTH(2 ** SAMPLE_BITS)) u_tone (
      .clk   (clk),
      .we    (cmd.table_we && table_channel == 2'(k)),
      .waddr (pixel_value[SAMPLE_BITS-1:0]),
      .wdata (table_value),
      .raddr (pixel_value[SAMPLE_BITS-1:0]),
      .rdata (tone[k])
    );
  end

  // Block sums, three channels packed per slot.
  logic [3*SUMW-1:0] sum_rd, sum_wr;
  logic [SUMW-1:0]   sum_new [3];
  logic              two [3];
  logic [4:0]        cs  [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cs[k]      = chan_sites(cell_colors, 2'(k));
      two[k]     = cs[k][4];
      sum_new[k] = (first ? '0 : sum_rd[k*SUMW +: SUMW])
                 + (cs[k][site] ? SUMW'(tone[k]) : '0);
    end
    sum_wr = sts.emit ? '0 : {sum_new[2], sum_new[1], sum_new[0]};
  end

  bbd_ram #(.WIDTH(3 * SUMW), .DEPTH(MAX_WIDTH / 2)) u_sums (
    .clk   (clk),
    .we    (cmd.commit),
    .waddr (blk),
    .wdata (sum_wr),
    .raddr (blk),
    .rdata (sum_rd)
  );

  // Edge block dividers.
  logic [SUMW-1:0] quo [3];
  logic            dv_done [3];

  for (genvar k = 0; k < 3; k++) begin : g_div
    bbd_div #(.NW(SUMW), .DW(DVW)) u_div (
      .clk      (clk),
      .rst      (rst),
      .start    (cmd.div_start),
      .dividend (sum_new[k]),
      .divisor  (two[k] ? {cells, 1'b0} : {1'b0, cells}),
      .quotient (quo[k]),
      .done     (dv_done[k])
    );
  end

  assign sts.div_done = dv_done[0];

  // Pending result.
  logic [7:0] res [3];
  logic       res_row_end, res_frame_end;
  logic [3:0] shamt [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      shamt[k] = 4'({bin, 1'b0}) - 4'd2 + (two[k] ? 4'd1 : 4'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && sts.emit) begin
      for (int k = 0; k < 3; k++) begin
        res[k] <= 8'(sum_new[k] >> shamt[k]);
      end
      res_row_end   <= col_last;
      res_frame_end <= col_last && row_last;
    end else if (sts.div_done) begin
      for (int k = 0; k < 3; k++) begin
        res[k] <= quo[k][7:0];
      end
    end
    if (cmd.load_out) begin
      red       <= res[0];
      green     <= res[1];
      blue      <= res[2];
      row_end   <= res_row_end;
      frame_end <= res_frame_end;
    end
  end

  // Raster position.
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col <= '0;
      row <= '0;
    end else if (cmd.commit) begin
      if (col_last) begin
        col <= '0;
        row <= row_last ? 16'd0 : row + 16'd1;
      end else begin
        col <= col + CB'(1);
      end
    end
  end
endmodule

// File: rtl/bayer_bin_downscale.sv
// Sequence: a pixel is taken with its table and sum read, then added and written back; a
// full block result then moves to the output register, an edge block result only after
// the dividers' 2*MAX_BIN+8 steps. The input is held during each block sum
// read-modify-write, and while a closing pixel waits for its result to be loaded,
// through any division and output stall; table writes are taken back to back.
// Reset (rst, synchronous) restores RGGB, bin 1, 1024x1024, region start.
module bayer_bin_downscale #(
  parameter int SAMPLE_BITS = bbd_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_WIDTH   = bbd_pkg::MAX_WIDTH_DEF,
  parameter int MAX_BIN     = bbd_pkg::MAX_BIN_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        op,
  input  logic [15:0] pixel_value,
  input  logic [1:0]  table_channel,
  input  logic [7:0]  table_value,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic        row_end,
  output logic        frame_end
);
  import bbd_pkg::*;

  logic [7:0]  cell_colors;
  logic [2:0]  bin_shift;
  logic [12:0] region_width;
  logic [15:0] region_height;
  logic        cfg_wr;
  logic [1:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[3:2];

  // Register file: any write restarts the region.
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_colors   <= CELL_COLORS_RST;
      bin_shift     <= BIN_SHIFT_RST;
      region_width  <= REGION_WIDTH_RST;
      region_height <= REGION_HEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_CELL_COLORS:   cell_colors   <= pwdata[7:0];
        REG_BIN_SHIFT:     bin_shift     <= pwdata[2:0];
        REG_REGION_WIDTH:  region_width  <= pwdata[12:0];
        REG_REGION_HEIGHT: region_height <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_CELL_COLORS:   prdata = {24'd0, cell_colors};
      REG_BIN_SHIFT:     prdata = {29'd0, bin_shift};
      REG_REGION_WIDTH:  prdata = {19'd0, region_width};
      REG_REGION_HEIGHT: prdata = {16'd0, region_height};
      default:           prdata = '0;
    endcase
  end

  bbd_cmd_t    cmd;
  bbd_status_t sts;

  // Sequence each pixel through read and accumulate, and a closing one on through any division and output.
  bbd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bbd_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_BIN     (MAX_BIN)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .restart       (cfg_wr),
    .cell_colors   (cell_colors),
    .bin_shift     (bin_shift),
    .region_width  (region_width),
    .region_height (region_height),
    .pixel_value   (pixel_value),
    .table_channel (table_channel),
    .table_value   (table_value),
    .red           (red),
    .green         (green),
    .blue          (blue),
    .row_end       (row_end),
    .frame_end     (frame_end)
  );
endmodule

// File: rtl/bbd_checker.sv
// Port-level checks for the Bayer binning downscaler, bound to the top level.
// Depends only on the top level's ports.
module bbd_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       op,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] red,
  input logic [7:0] green,
  input logic [7:0] blue,
  input logic       row_end,
  input logic       frame_end
);
  // Hold a stalled result.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable({red, green, blue, row_end, frame_end}))
    else $error("stalled result changed");

  // A table write never produces a result.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !op && !out_valid |=> !out_valid)
    else $error("result after table write");

  // A pixel occupies the block in its accumulate state.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && op |=> !in_ready)
    else $error("request taken during accumulate");

  // The last block of a region also ends its row.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_end |-> row_end)
    else $error("frame end without row end");

  // Nothing is pending right after reset.
  assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid after reset");
endmodule

bind bayer_bin_downscale bbd_checker u_bbd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .op        (op),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .red       (red),
  .green     (green),
  .blue      (blue),
  .row_end   (row_end),
  .frame_end (frame_end)
);

// File: tb/tb.sv
// Testbench for bayer_bin_downscale: a directed table, then randomized pixel and
// tone table traffic under several region settings, checked by a local predictor.
// Depends on bbd_pkg and the bayer_bin_downscale RTL only.
module tb;
  import bbd_pkg::*;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       row_end;
    logic       frame_end;
  } binned_rgb_t;

  typedef struct {
    logic        op;
    logic [15:0] pix;
    logic [1:0]  chan;
    logic [7:0]  val;
    bit          known;   // expected result typed in below
    binned_rgb_t res;
  } dir_row_t;

  localparam int N_DIR      = 22;
  localparam int DRAIN_WAIT = 2 * MAX_BIN_DEF + 24;
  localparam int SUM_SLOTS  = MAX_WIDTH_DEF / 2;

  logic        clk, rst;
  logic        psel, penable, pwrite, pready;
  logic [3:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        in_valid, in_ready, op;
  logic [15:0] pixel_value;
  logic [1:0]  table_channel;
  logic [7:0]  table_value;
  logic        out_valid, out_ready;
  logic [7:0]  red, green, blue;
  logic        row_end, frame_end;

  // register mirror and predictor state
  logic [7:0]  cfg_colors;
  logic [2:0]  cfg_bin;
  logic [12:0] cfg_width;
  logic [15:0] cfg_height;
  logic [7:0]  tone_map [3][int];
  int unsigned bin_sums [SUM_SLOTS][3];
  int unsigned pos_col, pos_row;
  int unsigned mapped_pool [$];   // samples written in all three tables
  binned_rgb_t pending_rgb [$];
  int          fails;
  int          src_pct, snk_pct;
  dir_row_t    dir_rows [N_DIR];

  bayer_bin_downscale dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .op(op), .pixel_value(pixel_value),
    .table_channel(table_channel), .table_value(table_value),
    .out_valid(out_valid), .out_ready(out_ready), .red(red), .green(green),
    .blue(blue), .row_end(row_end), .frame_end(frame_end)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Drop everything the block holds for the region; tone tables survive.
  task automatic clear_region();
    foreach (bin_sums[i, c]) bin_sums[i][c] = 0;
    pos_col = 0;
    pos_row = 0;
  endtask

  // Work out the result a request causes, if any, and advance the mirror state.
  task automatic bin_predict(input logic rop, input logic [15:0] pix, input logic [1:0] chan,
                             input logic [7:0] val, output bit hit, output binned_rgb_t res);
    int unsigned bin, stp, width, height, col, row, site, blk, pw, ph, cells, v, cnt, x0, y0;
    logic [3:0]  mask [3];
    bit          two [3];
    bit          lx, ly, cut;
    hit = 0;
    res = '{default: '0};
    if (rop == OP_TABLE) begin
      if (chan != 2'd3) tone_map[chan][pix] = val;   // drop writes to the spare channel
      return;
    end
    bin = (cfg_bin < 1) ? 1 : ((cfg_bin > MAX_BIN_DEF) ? MAX_BIN_DEF : cfg_bin);
    stp = 1 << bin;
    width = (cfg_width < 2) ? 2 : ((cfg_width > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : cfg_width);
    height = (cfg_height < 2) ? 2 : cfg_height;
    col = (pos_col >= width) ? width - 1 : pos_col;
    row = pos_row;
    site = ((row & 1) << 1) | (col & 1);
    blk = (col >> bin) % SUM_SLOTS;
    for (int c = 0; c < 3; c++) begin
      mask[c] = '0;
      cnt = 0;
      for (int s = 0; s < 4; s++)
        if (cfg_colors[2*s +: 2] == c && cnt < 2) begin
          mask[c][s] = 1'b1;
          cnt++;
        end
      two[c] = (cnt == 2);
      if (cnt == 0) mask[c] = 4'b0001;   // absent colour rides on site 0
      if (mask[c][site]) bin_sums[blk][c] += tone_map[c][pix];
    end
    lx = ((col & (stp - 1)) == stp - 1) || (col == width - 1);
    ly = ((row & (stp - 1)) == stp - 1) || (row == height - 1);
    if (lx && ly) begin
      x0 = (col >> bin) << bin;
      y0 = (row >> bin) << bin;
      pw = (width - x0 < stp) ? width - x0 : stp;
      ph = (height - y0 < stp) ? height - y0 : stp;
      cut = (pw < stp) || (ph < stp);
      cells = ((pw + 1) >> 1) * ((ph + 1) >> 1);
      for (int c = 0; c < 3; c++) begin
        v = bin_sums[blk][c];
        if (cut) begin
          v = v / cells;
          if (two[c]) v = v / 2;
        end else begin
          v = v >> (2 * bin - 2 + (two[c] ? 1 : 0));
        end
        if (c == 0) res.red = v[7:0];
        else if (c == 1) res.green = v[7:0];
        else res.blue = v[7:0];
        bin_sums[blk][c] = 0;
      end
      res.row_end = (col == width - 1);
      res.frame_end = (col == width - 1) && (row == height - 1);
      hit = 1;
    end
    col++;
    if (col >= width) begin
      col = 0;
      row++;
      if (row >= height) row = 0;
    end
    pos_col = col;
    pos_row = row;
  endtask

  // Setup and access cycles; the register lands at the access edge.
  task automatic reg_write(input logic [1:0] idx, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_CELL_COLORS:   cfg_colors = data[7:0];
      REG_BIN_SHIFT:     cfg_bin = data[2:0];
      REG_REGION_WIDTH:  cfg_width = data[12:0];
      default:           cfg_height = data[15:0];
    endcase
    clear_region();
  endtask

  task automatic set_region(input logic [7:0] colors, input logic [2:0] bin,
                            input logic [12:0] width, input logic [15:0] height);
    reg_write(REG_CELL_COLORS, {24'd0, colors});
    reg_write(REG_BIN_SHIFT, {29'd0, bin});
    reg_write(REG_REGION_WIDTH, {19'd0, width});
    reg_write(REG_REGION_HEIGHT, {16'd0, height});
  endtask

  // Hold valid until the request is taken, then predict from what was accepted.
  task automatic send_request(input logic rop, input logic [15:0] pix, input logic [1:0] chan,
                              input logic [7:0] val, output bit hit, output binned_rgb_t res);
    int gap;
    gap = 0;
    while (src_pct > 0 && $urandom_range(99) < src_pct) gap++;
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= rop;
    pixel_value <= pix;
    table_channel <= chan;
    table_value <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bin_predict(rop, pix, chan, val, hit, res);
    if (hit) pending_rgb.push_back(res);
  endtask

  // Wait out every expected result, then let a stray edge-block division finish.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_rgb.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic pool_update(input logic [15:0] pix);
    int found [$];
    if (tone_map[0].exists(pix) && tone_map[1].exists(pix) && tone_map[2].exists(pix)) begin
      found = mapped_pool.find_first_index(x) with (x == {16'd0, pix});
      if (found.size() == 0) mapped_pool.push_back({16'd0, pix});
    end
  endtask

  // Mostly pixels from written samples; some table writes, a few to the spare channel.
  task automatic random_traffic(input int count);
    bit          hit;
    binned_rgb_t res;
    logic [15:0] pix;
    logic [1:0]  chan;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 82) begin
        pix = 16'(mapped_pool[$urandom_range(mapped_pool.size() - 1)]);
        send_request(OP_PIXEL, pix, 2'($urandom), 8'($urandom), hit, res);
      end else begin
        pix = $urandom_range(1) ? 16'(mapped_pool[$urandom_range(mapped_pool.size() - 1)])
                                : 16'($urandom);
        chan = 2'($urandom_range(3));
        send_request(OP_TABLE, pix, chan, 8'($urandom), hit, res);
        pool_update(pix);
      end
      if (i == count / 2 && $urandom_range(3) == 0) drain();   // hold off mid-phase
    end
  endtask

  // Stall the result side at the rate of the current phase.
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= (snk_pct == 0) || ($urandom_range(99) >= snk_pct);
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    binned_rgb_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_rgb.size() == 0) begin
        $error("result with none expected: r=%0d g=%0d b=%0d", red, green, blue);
        fails++;
      end else begin
        want = pending_rgb.pop_front();
        if (red !== want.red) begin
          $error("red: expected %0d, got %0d", want.red, red);
          fails++;
        end
        if (green !== want.green) begin
          $error("green: expected %0d, got %0d", want.green, green);
          fails++;
        end
        if (blue !== want.blue) begin
          $error("blue: expected %0d, got %0d", want.blue, blue);
          fails++;
        end
        if (row_end !== want.row_end) begin
          $error("row_end: expected %0d, got %0d", want.row_end, row_end);
          fails++;
        end
        if (frame_end !== want.frame_end) begin
          $error("frame_end: expected %0d, got %0d", want.frame_end, frame_end);
          fails++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    bit          hit;
    binned_rgb_t res;
    int          mode;
    fails = 0;
    src_pct = 0;
    snk_pct = 0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    op = OP_TABLE;
    pixel_value = '0;
    table_channel = CH_RED;
    table_value = '0;
    cfg_colors = CELL_COLORS_RST;
    cfg_bin = BIN_SHIFT_RST;
    cfg_width = REGION_WIDTH_RST;
    cfg_height = REGION_HEIGHT_RST;
    clear_region();

    // Directed rows on a 2x2 RGGB region: every pixel quad closes a block.
    dir_rows[0]  = '{OP_TABLE, 16'hFFFF, CH_RED,   8'hFF, 0, '{default: '0}};
    dir_rows[1]  = '{OP_TABLE, 16'hFFFF, CH_GREEN, 8'hFF, 0, '{default: '0}};
    dir_rows[2]  = '{OP_TABLE, 16'hFFFF, CH_BLUE,  8'hFF, 0, '{default: '0}};
    dir_rows[3]  = '{OP_TABLE, 16'h0000, CH_RED,   8'h00, 0, '{default: '0}};
    dir_rows[4]  = '{OP_TABLE, 16'h0000, CH_GREEN, 8'h00, 0, '{default: '0}};
    dir_rows[5]  = '{OP_TABLE, 16'h0000, CH_BLUE,  8'h00, 0, '{default: '0}};
    dir_rows[6]  = '{OP_TABLE, 16'h0000, 2'd3,     8'h4D, 0, '{default: '0}};  // ignored
    for (int i = 7; i < 11; i++)
      dir_rows[i] = '{OP_PIXEL, 16'hFFFF, CH_RED, 8'h00, 0, '{default: '0}};
    dir_rows[10].known = 1;
    dir_rows[10].res = '{8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1};
    for (int i = 11; i < 15; i++)
      dir_rows[i] = '{OP_PIXEL, 16'h0000, CH_BLUE, 8'hFF, 0, '{default: '0}};
    dir_rows[14].known = 1;
    dir_rows[14].res = '{8'h00, 8'h00, 8'h00, 1'b1, 1'b1};
    dir_rows[15] = '{OP_TABLE, 16'h5A5A, CH_RED,   8'hA5, 0, '{default: '0}};
    dir_rows[16] = '{OP_TABLE, 16'h5A5A, CH_GREEN, 8'h3C, 0, '{default: '0}};
    dir_rows[17] = '{OP_TABLE, 16'h5A5A, CH_BLUE,  8'h81, 0, '{default: '0}};
    dir_rows[18] = '{OP_PIXEL, 16'h5A5A, CH_RED, 8'h00, 0, '{default: '0}};
    dir_rows[19] = '{OP_PIXEL, 16'h0000, CH_RED, 8'h00, 0, '{default: '0}};
    dir_rows[20] = '{OP_PIXEL, 16'hFFFF, CH_RED, 8'h00, 0, '{default: '0}};
    dir_rows[21] = '{OP_PIXEL, 16'h5A5A, CH_RED, 8'h00, 0, '{default: '0}};

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_region(8'd148, 3'd1, 13'd2, 16'd2);
    foreach (dir_rows[i]) begin
      send_request(dir_rows[i].op, dir_rows[i].pix, dir_rows[i].chan, dir_rows[i].val,
                   hit, res);
      if (dir_rows[i].known && (!hit || res != dir_rows[i].res)) begin
        $error("directed row %0d: predicted result disagrees with the table", i);
        fails++;
      end
    end
    mapped_pool = '{16'h0000, 16'hFFFF, 16'h5A5A};
    drain();

    // Random phases; idling mode rotates: none, sender, receiver, both.
    for (int ph = 0; ph < 11; ph++) begin
      mode = ph % 4;
      src_pct = (mode == 1) ? 60 : ((mode == 3) ? 30 : 0);
      snk_pct = (mode == 2) ? 60 : ((mode == 3) ? 30 : 0);
      case (ph)
        0: set_region(8'd148, 3'd4, 13'd16, 16'd16);
        1: set_region(8'($urandom), 3'd0, 13'd0, 16'd0);
        2: set_region(8'($urandom), 3'd7, 13'd8191, 16'd65535);
        3: set_region(8'hFF, 3'd4, 13'd4096, 16'd3);
        4: set_region(8'h00, 3'd2, 13'd7, 16'd5);
        5: set_region(8'hE4, 3'd3, 13'd13, 16'd11);
        default: set_region(8'($urandom), 3'($urandom_range(7)), 13'($urandom_range(24)),
                            16'($urandom_range(20)));
      endcase
      random_traffic(ph == 0 ? 100 : 70);
      if (ph == 3) drain();   // sender waits for every outstanding result
      drain();
    end

    drain();
    if (fails == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
